/* rtl/icvd_pkg.sv */
`timescale 1ns / 1ps

package icvd_pkg;

  localparam int unsigned CoefWidth  = 16;
  localparam int unsigned ProdWidth  = 2 * CoefWidth;
  localparam int unsigned BoundWidth = 48;
  localparam int unsigned DiffWidth  = BoundWidth + 1;
  localparam int unsigned DistWidth  = 58;

  typedef struct packed {
    logic signed [CoefWidth-1:0]  coefficient;
    logic signed [CoefWidth-1:0]  var_value;
    logic signed [BoundWidth-1:0] row_low;
    logic signed [BoundWidth-1:0] row_high;
    logic                         end_of_row;
    logic                         end_of_check;
  } in_t;

  typedef struct packed {
    logic [DistWidth-1:0] total_distance;
    logic                 all_satisfied;
  } out_t;

  // one row-distance beat handed from the row pipeline to the accumulator
  typedef struct packed {
    logic                 valid;
    logic                 row_close;
    logic                 check_end;
    logic [DiffWidth-1:0] distance;
  } row_dist_t;

endpackage

/* rtl/icvd_row_pipe.sv */
`timescale 1ns / 1ps

module icvd_row_pipe import icvd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      advance_i,
  input  logic      in_valid_i,
  input  in_t       in_data_i,
  output row_dist_t dist_o
);

  // input register
  logic s1_valid_q;
  in_t  s1_q;

  // product stage
  logic                         s2_valid_q, s2_close_q, s2_eoc_q;
  logic signed [ProdWidth-1:0]  s2_prod_q;
  logic signed [BoundWidth-1:0] s2_lo_q, s2_hi_q;

  // row sum stage
  logic                         s3_valid_q, s3_close_q, s3_eoc_q;
  logic signed [BoundWidth-1:0] s3_sum_q, s3_lo_q, s3_hi_q;

  logic signed [BoundWidth-1:0] row_acc_q, row_acc_d;
  logic signed [BoundWidth-1:0] sum_d;

  // row distance stage
  logic                 dist_valid_q, dist_close_q, dist_eoc_q;
  logic [DiffWidth-1:0] dist_diff_q;

  logic signed [DiffWidth-1:0] sum_x, lo_x, hi_x;
  logic        [DiffWidth-1:0] diff_d;

  assign sum_d = row_acc_q + {{(BoundWidth-ProdWidth){s2_prod_q[ProdWidth-1]}}, s2_prod_q};

  always_comb begin
    row_acc_d = row_acc_q;
    if (advance_i && s2_valid_q) begin
      row_acc_d = s2_close_q ? '0 : sum_d;
    end
  end

  assign sum_x = {s3_sum_q[BoundWidth-1], s3_sum_q};
  assign lo_x  = {s3_lo_q[BoundWidth-1], s3_lo_q};
  assign hi_x  = {s3_hi_q[BoundWidth-1], s3_hi_q};

  // lower bound is tested first, so inverted bounds still give a distance
  always_comb begin
    diff_d = '0;
    if (s3_sum_q < s3_lo_q) begin
      diff_d = DiffWidth'(lo_x - sum_x);
    end else if (s3_sum_q > s3_hi_q) begin
      diff_d = DiffWidth'(sum_x - hi_x);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      s2_valid_q   <= 1'b0;
      s3_valid_q   <= 1'b0;
      dist_valid_q <= 1'b0;
      row_acc_q    <= '0;
    end else begin
      row_acc_q <= row_acc_d;
      if (advance_i) begin
        s1_valid_q   <= in_valid_i;
        s2_valid_q   <= s1_valid_q;
        s3_valid_q   <= s2_valid_q;
        dist_valid_q <= s3_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_q <= in_data_i;

      s2_prod_q  <= s1_q.coefficient * s1_q.var_value;
      s2_lo_q    <= s1_q.row_low;
      s2_hi_q    <= s1_q.row_high;
      s2_close_q <= s1_q.end_of_row | s1_q.end_of_check;
      s2_eoc_q   <= s1_q.end_of_check;

      s3_sum_q   <= sum_d;
      s3_lo_q    <= s2_lo_q;
      s3_hi_q    <= s2_hi_q;
      s3_close_q <= s2_close_q;
      s3_eoc_q   <= s2_eoc_q;

      dist_diff_q  <= diff_d;
      dist_close_q <= s3_close_q;
      dist_eoc_q   <= s3_eoc_q;
    end
  end

  assign dist_o = {dist_valid_q, dist_close_q, dist_eoc_q, dist_diff_q};

endmodule

/* rtl/interval_constraint_violation_distance.sv */
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Payload
// in      | input     | in_valid_i / in_stall_o | in_data_i  (icvd_pkg::in_t)
// out     | output    | out_valid_o/ out_stall_i| out_data_o (icvd_pkg::out_t)
//
// One beat is taken every cycle while in_stall_o is low; out_valid_o rises once an
// accepted end-of-check beat has passed the product, row sum, row distance and
// result registers. The row and saturating distance accumulators are unpipelined.
// rst_ni clears all pipeline valids and both accumulators asynchronously.
// in_stall_o rises only while a finished result is held and a new one arrives
// at the last stage; the whole pipeline holds then.

module interval_constraint_violation_distance import icvd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  row_dist_t row_dist;
  logic      advance;
  logic      block;

  logic [DistWidth-1:0] dist_acc_q, dist_acc_d, dist_sum;
  logic [DistWidth:0]   dist_wide;
  logic                 out_valid_q;
  out_t                 out_q;

  // hold everything while the held result waits and another one is ready
  assign block   = row_dist.valid & row_dist.check_end & out_valid_q & out_stall_i;
  assign advance = ~block;

  icvd_row_pipe u_row_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .in_valid_i(in_valid_i),
    .in_data_i (in_data_i),
    .dist_o    (row_dist)
  );

  assign dist_wide = {1'b0, dist_acc_q} + (DistWidth+1)'(row_dist.distance);
  assign dist_sum  = dist_wide[DistWidth] ? '1 : dist_wide[DistWidth-1:0];

  always_comb begin
    dist_acc_d = dist_acc_q;
    if (advance && row_dist.valid) begin
      if (row_dist.check_end) begin
        dist_acc_d = '0;
      end else if (row_dist.row_close) begin
        dist_acc_d = dist_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_acc_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      dist_acc_q <= dist_acc_d;
      if (advance && row_dist.valid && row_dist.check_end) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && row_dist.valid && row_dist.check_end) begin
      out_q.total_distance <= dist_sum;
      out_q.all_satisfied  <= (dist_sum == '0);
    end
  end

  assign in_stall_o  = block;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
